// File: design/journal_record_parser_core_assert.svh
// Assertion macros for the journal record parser.
`ifndef JOURNAL_RECORD_PARSER_CORE_ASSERT_SVH
`define JOURNAL_RECORD_PARSER_CORE_ASSERT_SVH

// Checked only outside reset.
`define JRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define JRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/jrp_pkg.sv
package jrp_pkg;

  localparam logic [2:0] KIND_HEADER      = 3'd0;
  localparam logic [2:0] KIND_CHANNEL     = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD     = 3'd2;
  localparam logic [2:0] KIND_TRUNCATED   = 3'd3;
  localparam logic [2:0] KIND_BAD_VERSION = 3'd4;
  localparam logic [2:0] KIND_INVALID     = 3'd5;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_CHANNEL = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_TRAIL   = 3'd3;
  localparam logic [2:0] PH_SWALLOW = 3'd4;

  // Header byte offsets; each field *_END is one past it; POS_END is the last byte.
  localparam logic [5:0] POS_VERSION_END = 6'd4;
  localparam logic [5:0] POS_META_END    = 6'd12;
  localparam logic [5:0] POS_GEN_END     = 6'd20;
  localparam logic [5:0] POS_RECV_END    = 6'd28;
  localparam logic [5:0] POS_OBS_END     = 6'd36;
  localparam logic [5:0] POS_FLAG        = 6'd44;
  localparam logic [5:0] POS_EXCH        = 6'd45;
  localparam logic [5:0] POS_SIZES       = 6'd53;
  localparam logic [5:0] POS_SIZE1       = 6'd57;
  localparam logic [5:0] POS_END         = 6'd60;

  localparam logic [1:0] CFG_EXPECTED_VERSION = 2'd0;
  localparam logic [1:0] CFG_MAX_CHANNEL      = 2'd1;
  localparam logic [1:0] CFG_MAX_PAYLOAD      = 2'd2;

  localparam logic [31:0] RESET_VERSION     = 32'd2;
  localparam logic [8:0]  RESET_MAX_CHANNEL = 9'd256;
  localparam logic [24:0] RESET_MAX_PAYLOAD = 25'd16777216;

  typedef struct packed {
    logic [2:0]         kind;
    logic [63:0]        meta_version;
    logic [63:0]        conn_generation;
    logic signed [63:0] received_time;
    logic signed [63:0] observed_time;
    logic [63:0]        sequence_number;
    logic               exchange_present;
    logic signed [63:0] exch_time;
    logic [8:0]         channel_length;
    logic [24:0]        payload_length;
    logic [7:0]         out_byte;
    logic               record_end;
  } result_t;

endpackage

// File: design/journal_record_parser_core.sv
// Journal record parser.
// Input channel: one record byte per word (data_byte) with last_byte set on
// the final byte of the record buffer; accepted when in_valid is high and
// in_stall is low. Output channel: at most one result word per input byte,
// accepted when out_valid is high and out_stall is low. kind tells a header
// result, a channel or payload byte (out_byte), or an error (truncated, bad
// version, invalid); after an error bytes are dropped up to the last mark.
// Configuration: cfg_write with cfg_index and cfg_data sets the expected
// version and the channel and payload length limits; write only when idle.
// Result: registered, it appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle when not stalled; all per-byte work is one
// shift or counter step from parser state registers to the output register.
// Stall: in_stall follows out_valid && out_stall, so the output register
// holds while the receiver stalls and a new byte enters as soon as the held
// word leaves.
// Reset: synchronous rst clears out_valid, returns the parser to the start
// of a header and restores the configuration defaults.
`include "journal_record_parser_core_assert.svh"

module journal_record_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         kind,
  output logic [63:0]        meta_version,
  output logic [63:0]        conn_generation,
  output logic signed [63:0] received_time,
  output logic signed [63:0] observed_time,
  output logic [63:0]        sequence_number,
  output logic               exchange_present,
  output logic signed [63:0] exch_time,
  output logic [8:0]         channel_length,
  output logic [24:0]        payload_length,
  output logic [7:0]         out_byte,
  output logic               record_end
);

  logic [31:0] expected_version;
  logic [8:0]  max_channel_length;
  logic [24:0] max_payload_length;

  logic [2:0]  phase, phase_next;
  logic [5:0]  header_position, header_position_next;
  logic [31:0] version_field, version_field_next;
  logic [63:0] metadata_field, metadata_field_next;
  logic [63:0] generation_field, generation_field_next;
  logic [63:0] received_field, received_field_next;
  logic [63:0] observed_field, observed_field_next;
  logic [63:0] sequence_field, sequence_field_next;
  logic [63:0] exchange_field, exchange_field_next;
  logic [7:0]  flag_field, flag_field_next;
  logic [31:0] size_channel, size_channel_next;
  logic [31:0] size_payload, size_payload_next;
  logic [24:0] body_count, body_count_next;

  logic [24:0]          body_inc;
  logic                 res_valid;
  jrp_pkg::result_t     res;
  jrp_pkg::result_t     result;
  logic                 in_accept;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign body_inc  = body_count + 25'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version   <= jrp_pkg::RESET_VERSION;
      max_channel_length <= jrp_pkg::RESET_MAX_CHANNEL;
      max_payload_length <= jrp_pkg::RESET_MAX_PAYLOAD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        jrp_pkg::CFG_EXPECTED_VERSION: expected_version   <= cfg_data;
        jrp_pkg::CFG_MAX_CHANNEL:      max_channel_length <= cfg_data[8:0];
        jrp_pkg::CFG_MAX_PAYLOAD:      max_payload_length <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next            = phase;
    header_position_next  = header_position;
    version_field_next    = version_field;
    metadata_field_next   = metadata_field;
    generation_field_next = generation_field;
    received_field_next   = received_field;
    observed_field_next   = observed_field;
    sequence_field_next   = sequence_field;
    exchange_field_next   = exchange_field;
    flag_field_next       = flag_field;
    size_channel_next     = size_channel;
    size_payload_next     = size_payload;
    body_count_next       = body_count;
    res_valid             = 1'b0;
    res                   = '0;
    res.record_end        = last_byte;

    unique case (phase)
      jrp_pkg::PH_HEADER: begin
        if (header_position == 6'd0) begin
          exchange_field_next = 64'd0;
        end
        if (header_position < jrp_pkg::POS_VERSION_END) begin
          version_field_next = {data_byte, version_field[31:8]};
        end else if (header_position < jrp_pkg::POS_META_END) begin
          metadata_field_next = {data_byte, metadata_field[63:8]};
        end else if (header_position < jrp_pkg::POS_GEN_END) begin
          generation_field_next = {data_byte, generation_field[63:8]};
        end else if (header_position < jrp_pkg::POS_RECV_END) begin
          received_field_next = {data_byte, received_field[63:8]};
        end else if (header_position < jrp_pkg::POS_OBS_END) begin
          observed_field_next = {data_byte, observed_field[63:8]};
        end else if (header_position < jrp_pkg::POS_FLAG) begin
          sequence_field_next = {data_byte, sequence_field[63:8]};
        end else if (header_position == jrp_pkg::POS_FLAG) begin
          flag_field_next = data_byte;
        end else if (header_position < jrp_pkg::POS_SIZES) begin
          exchange_field_next = {data_byte, exchange_field[63:8]};
        end else if (header_position < jrp_pkg::POS_SIZE1) begin
          size_channel_next = {data_byte, size_channel[31:8]};
        end else begin
          size_payload_next = {data_byte, size_payload[31:8]};
        end

        if (header_position == jrp_pkg::POS_FLAG) begin
          if (version_field != expected_version) begin
            res_valid = 1'b1;
            res.kind  = jrp_pkg::KIND_BAD_VERSION;
          end else if (data_byte > 8'd1) begin
            res_valid = 1'b1;
            res.kind  = jrp_pkg::KIND_INVALID;
          end else if (last_byte) begin
            res_valid = 1'b1;
            res.kind  = jrp_pkg::KIND_TRUNCATED;
          end else begin
            header_position_next = data_byte[0] ? jrp_pkg::POS_EXCH : jrp_pkg::POS_SIZES;
          end
        end else if (header_position >= jrp_pkg::POS_END) begin
          res_valid = 1'b1;
          if (size_channel == 32'd0 || size_channel > {23'd0, max_channel_length} ||
              size_payload_next == 32'd0 ||
              size_payload_next > {7'd0, max_payload_length} ||
              last_byte || metadata_field == 64'd0 || generation_field == 64'd0) begin
            res.kind = jrp_pkg::KIND_INVALID;
          end else begin
            res.kind                  = jrp_pkg::KIND_HEADER;
            res.meta_version          = metadata_field;
            res.conn_generation       = generation_field;
            res.received_time         = received_field;
            res.observed_time         = observed_field;
            res.sequence_number       = sequence_field;
            res.exchange_present      = flag_field[0];
            res.exch_time             = (flag_field != 8'd0) ? exchange_field : 64'd0;
            res.channel_length        = size_channel[8:0];
            res.payload_length        = size_payload_next[24:0];
            header_position_next      = 6'd0;
            body_count_next           = 25'd0;
            phase_next                = jrp_pkg::PH_CHANNEL;
          end
        end else if (last_byte) begin
          res_valid = 1'b1;
          res.kind  = jrp_pkg::KIND_TRUNCATED;
        end else begin
          header_position_next = header_position + 6'd1;
        end

        // error results end the header here
        if (res_valid && res.kind != jrp_pkg::KIND_HEADER) begin
          header_position_next = 6'd0;
          phase_next           = last_byte ? jrp_pkg::PH_HEADER : jrp_pkg::PH_SWALLOW;
        end
      end

      jrp_pkg::PH_CHANNEL: begin
        res_valid = 1'b1;
        if (last_byte) begin
          res.kind             = jrp_pkg::KIND_INVALID;
          header_position_next = 6'd0;
          phase_next           = jrp_pkg::PH_HEADER;
        end else begin
          res.kind        = jrp_pkg::KIND_CHANNEL;
          res.out_byte    = data_byte;
          body_count_next = body_inc;
          if ({7'd0, body_inc} >= size_channel) begin
            body_count_next = 25'd0;
            phase_next      = jrp_pkg::PH_PAYLOAD;
          end
        end
      end

      jrp_pkg::PH_PAYLOAD: begin
        res_valid       = 1'b1;
        body_count_next = body_inc;
        if ({7'd0, body_inc} >= size_payload) begin
          res.kind             = jrp_pkg::KIND_PAYLOAD;
          res.out_byte         = data_byte;
          header_position_next = 6'd0;
          phase_next           = last_byte ? jrp_pkg::PH_HEADER : jrp_pkg::PH_TRAIL;
        end else if (last_byte) begin
          res.kind             = jrp_pkg::KIND_INVALID;
          header_position_next = 6'd0;
          phase_next           = jrp_pkg::PH_HEADER;
        end else begin
          res.kind     = jrp_pkg::KIND_PAYLOAD;
          res.out_byte = data_byte;
        end
      end

      jrp_pkg::PH_TRAIL: begin
        res_valid            = 1'b1;
        res.kind             = jrp_pkg::KIND_INVALID;
        header_position_next = 6'd0;
        phase_next           = last_byte ? jrp_pkg::PH_HEADER : jrp_pkg::PH_SWALLOW;
      end

      default: begin
        // drop bytes until the last mark
        if (last_byte) begin
          header_position_next = 6'd0;
          phase_next           = jrp_pkg::PH_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= jrp_pkg::PH_HEADER;
      header_position  <= 6'd0;
      version_field    <= 32'd0;
      metadata_field   <= 64'd0;
      generation_field <= 64'd0;
      received_field   <= 64'd0;
      observed_field   <= 64'd0;
      sequence_field   <= 64'd0;
      exchange_field   <= 64'd0;
      flag_field       <= 8'd0;
      size_channel     <= 32'd0;
      size_payload     <= 32'd0;
      body_count       <= 25'd0;
    end else if (in_accept) begin
      phase            <= phase_next;
      header_position  <= header_position_next;
      version_field    <= version_field_next;
      metadata_field   <= metadata_field_next;
      generation_field <= generation_field_next;
      received_field   <= received_field_next;
      observed_field   <= observed_field_next;
      sequence_field   <= sequence_field_next;
      exchange_field   <= exchange_field_next;
      flag_field       <= flag_field_next;
      size_channel     <= size_channel_next;
      size_payload     <= size_payload_next;
      body_count       <= body_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      result <= res;
    end
  end

  assign kind                  = result.kind;
  assign meta_version          = result.meta_version;
  assign conn_generation       = result.conn_generation;
  assign received_time         = result.received_time;
  assign observed_time         = result.observed_time;
  assign sequence_number       = result.sequence_number;
  assign exchange_present      = result.exchange_present;
  assign exch_time             = result.exch_time;
  assign channel_length        = result.channel_length;
  assign payload_length        = result.payload_length;
  assign out_byte              = result.out_byte;
  assign record_end            = result.record_end;

  `JRP_ASSERT_ALWAYS(a_reset_clears_output, rst |=> !out_valid,
    "output word valid right after reset")
  `JRP_ASSERT(a_header_ids_nonzero,
    out_valid && kind == jrp_pkg::KIND_HEADER |->
      meta_version != 64'd0 && conn_generation != 64'd0 && !record_end,
    "header result with zero id or end mark")
  `JRP_ASSERT(a_position_idle_in_body,
    phase != jrp_pkg::PH_HEADER |-> header_position == 6'd0,
    "header position left nonzero outside header phase")
  `JRP_ASSERT(a_byte_only_on_pass,
    out_valid && kind != jrp_pkg::KIND_CHANNEL && kind != jrp_pkg::KIND_PAYLOAD |->
      out_byte == 8'd0,
    "out_byte set on a non pass-through result")
  `JRP_ASSERT(a_channel_byte_gives_result,
    in_accept && phase == jrp_pkg::PH_CHANNEL |=>
      out_valid && (kind == jrp_pkg::KIND_CHANNEL || kind == jrp_pkg::KIND_INVALID),
    "channel byte produced no channel or invalid result")

endmodule
